@@ hdl/egss_pkg.sv @@
// ----------------------------------------------------------------------------
// egss_pkg
// Shared widths, reset values, register indexes and control types for the
// gated step sequencer.
// ----------------------------------------------------------------------------
package egss_pkg;

    localparam int MAX_STEPS_DEFAULT = 32;
    localparam int SAMPLE_W          = 16;
    localparam int COUNT_W           = 6;
    localparam int CFG_INDEX_W       = 4;

    localparam logic [COUNT_W-1:0] STEP_COUNT_RESET  = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] PULSE_COUNT_RESET = COUNT_W'(5);

    localparam logic signed [SAMPLE_W-1:0] CLOCK_THRESHOLD = 16'sd16384;

    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_COUNT  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_COUNT = CFG_INDEX_W'(1);

    // Control from the top level into the step/gate stage
    typedef struct packed {
        logic start;   // counts changed: recompute the wrap target
        logic fire;    // process the request held in the input register
    } gate_ctrl_t;

endpackage

@@ hdl/egss_pattern.sv @@
// ----------------------------------------------------------------------------
// egss_pattern
// Builds the hit pattern one step per cycle with a running remainder, so
// that no divider is needed.
// ----------------------------------------------------------------------------
module egss_pattern #(
    parameter int MAX_STEPS = egss_pkg::MAX_STEPS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [$clog2(MAX_STEPS+1)-1:0]   eff_steps,
    input  logic [egss_pkg::COUNT_W-1:0]     pulse_count,
    output logic                             busy,
    output logic [MAX_STEPS-1:0]             pattern
);

    localparam int IW = $clog2(MAX_STEPS);
    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam int RW = ((SW > egss_pkg::COUNT_W) ? SW : egss_pkg::COUNT_W) + 1;

    logic                 active_reg, active_next;
    logic [IW-1:0]        pos_reg, pos_next;
    logic [SW-1:0]        rem_reg, rem_next;
    logic [MAX_STEPS-1:0] pattern_reg, pattern_next;

    logic [RW-1:0] sum;
    logic [RW-1:0] steps_ext;
    logic          dense;
    logic          hit;
    logic          last;

    // Step p is a hit when a multiple of steps lies in [p*pulses, p*pulses+pulses-1];
    // rem_reg holds p*pulses mod steps.
    always_comb begin
        steps_ext = RW'(eff_steps);
        sum       = RW'(rem_reg) + RW'(pulse_count);
        dense     = RW'(pulse_count) >= steps_ext;
        hit       = (pulse_count != '0) &&
                    (dense || (rem_reg == '0) || (sum > steps_ext));
        last      = (SW'(pos_reg) + SW'(1)) == eff_steps;

        active_next  = active_reg;
        pos_next     = pos_reg;
        rem_next     = rem_reg;
        pattern_next = pattern_reg;

        if (start) begin
            active_next  = 1'b1;
            pos_next     = '0;
            rem_next     = '0;
            pattern_next = '0;
        end else if (active_reg) begin
            pattern_next[pos_reg] = hit;
            pos_next = pos_reg + IW'(1);
            if (dense) begin
                rem_next = '0;
            end else if (sum >= steps_ext) begin
                rem_next = SW'(sum - steps_ext);
            end else begin
                rem_next = SW'(sum);
            end
            if (last) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b1;
            pos_reg     <= '0;
            rem_reg     <= '0;
            pattern_reg <= '0;
        end else begin
            active_reg  <= active_next;
            pos_reg     <= pos_next;
            rem_reg     <= rem_next;
            pattern_reg <= pattern_next;
        end
    end

    assign busy    = active_reg;
    assign pattern = pattern_reg;

endmodule

@@ hdl/egss_gate.sv @@
// ----------------------------------------------------------------------------
// egss_gate
// Clock edge detection, step counter and sample gate, with the result
// register of the output channel.
// ----------------------------------------------------------------------------
module egss_gate #(
    parameter int MAX_STEPS = egss_pkg::MAX_STEPS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  egss_pkg::gate_ctrl_t                  ctrl,
    input  logic [$clog2(MAX_STEPS+1)-1:0]        eff_steps,
    input  logic [MAX_STEPS-1:0]                  pattern,
    input  logic signed [egss_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                  m_ready,
    output logic                                  wrap_busy,
    output logic                                  take,
    output logic                                  m_valid,
    output logic signed [egss_pkg::SAMPLE_W-1:0]  m_gated_sample
);

    localparam int IW = $clog2(MAX_STEPS);
    localparam int SW = $clog2(MAX_STEPS + 1);

    logic [IW-1:0] step_reg, step_next;
    logic          high_reg, high_next;
    logic [SW-1:0] wrap_reg, wrap_next;
    logic          valid_reg, valid_next;
    logic signed [egss_pkg::SAMPLE_W-1:0] data_reg, data_next;

    logic [SW-1:0] step_inc;
    logic [IW-1:0] step_adv;

    always_comb begin
        step_inc = SW'(step_reg) + SW'(1);
        // A step left above a lowered count wraps to the precomputed target
        if (SW'(step_reg) < eff_steps) begin
            step_adv = (step_inc == eff_steps) ? '0 : IW'(step_inc);
        end else begin
            step_adv = IW'(wrap_reg);
        end

        step_next  = step_reg;
        high_next  = high_reg;
        wrap_next  = wrap_reg;
        valid_next = valid_reg;
        data_next  = data_reg;

        if (ctrl.start) begin
            wrap_next = step_inc;
        end else if (wrap_busy) begin
            wrap_next = wrap_reg - eff_steps;
        end

        if (ctrl.fire) begin
            if (!high_reg && (sample > egss_pkg::CLOCK_THRESHOLD)) begin
                high_next = 1'b1;
                step_next = step_adv;
            end else if (high_reg && (sample < egss_pkg::CLOCK_THRESHOLD)) begin
                high_next = 1'b0;
            end
            valid_next = 1'b1;
            data_next  = pattern[step_next] ? sample : '0;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            high_reg  <= 1'b0;
            wrap_reg  <= SW'(1);
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            high_reg  <= high_next;
            wrap_reg  <= wrap_next;
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign wrap_busy      = wrap_reg >= eff_steps;
    assign take           = !valid_reg || m_ready;
    assign m_valid        = valid_reg;
    assign m_gated_sample = data_reg;

endmodule

@@ hdl/euclidean_gated_step_sequencer.sv @@
// ----------------------------------------------------------------------------
// euclidean_gated_step_sequencer
// Path: a request passes through the input register, then the result
// register; a rebuild or a stalled result can hold it in between.
// Throughput: one request per cycle unless a rebuild or stalled result holds
// it; the input register takes a new request while a finished result waits
// to be taken. Reset: counts return to 8 steps / 5 pulses, step 0, clock
// low; the pattern is then rebuilt step by step with both readies low.
// ----------------------------------------------------------------------------
module euclidean_gated_step_sequencer #(
    parameter int MAX_STEPS = egss_pkg::MAX_STEPS_DEFAULT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // request channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [egss_pkg::SAMPLE_W-1:0]    s_clock_sample,
    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [egss_pkg::SAMPLE_W-1:0]    m_gated_sample,
    // configuration write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [egss_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [egss_pkg::COUNT_W-1:0]            cfg_data
);

    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam int CW = (SW > egss_pkg::COUNT_W) ? SW : egss_pkg::COUNT_W;

    // Count registers
    logic [egss_pkg::COUNT_W-1:0] step_count_reg, step_count_next;
    logic [egss_pkg::COUNT_W-1:0] pulse_count_reg, pulse_count_next;

    // Input register
    logic                                 in_valid_reg, in_valid_next;
    logic signed [egss_pkg::SAMPLE_W-1:0] in_sample_reg, in_sample_next;

    logic [SW-1:0]        eff_steps;
    logic [MAX_STEPS-1:0] pattern;
    logic                 build_busy;
    logic                 wrap_busy;
    logic                 take;
    logic                 busy;
    logic                 cfg_fire;
    logic                 s_fire;
    egss_pkg::gate_ctrl_t gate_ctrl;

    // Clamp the step count: zero runs as one step, anything above the
    // storage runs as the full length.
    always_comb begin
        if (step_count_reg == '0) begin
            eff_steps = SW'(1);
        end else if (CW'(step_count_reg) > CW'(MAX_STEPS)) begin
            eff_steps = SW'(MAX_STEPS);
        end else begin
            eff_steps = SW'(step_count_reg);
        end
    end

    // Hold off both requests and configuration while the pattern or the
    // wrap target is being rebuilt. Hold configuration too while a request
    // still waits in the input register, so it runs on the old counts.
    assign busy      = build_busy || wrap_busy;
    assign cfg_ready = !busy && !in_valid_reg;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign gate_ctrl.fire  = in_valid_reg && take && !busy;
    assign gate_ctrl.start = cfg_fire && ((cfg_index == egss_pkg::CFG_STEP_COUNT) ||
                                          (cfg_index == egss_pkg::CFG_PULSE_COUNT));

    // The input register refills in the same cycle it hands its request on
    assign s_ready = !busy && (!in_valid_reg || gate_ctrl.fire);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        step_count_next  = step_count_reg;
        pulse_count_next = pulse_count_reg;
        if (cfg_fire) begin
            unique case (cfg_index)
                egss_pkg::CFG_STEP_COUNT:  step_count_next  = cfg_data;
                egss_pkg::CFG_PULSE_COUNT: pulse_count_next = cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end

        in_valid_next  = in_valid_reg;
        in_sample_next = in_sample_reg;
        if (s_fire) begin
            in_valid_next  = 1'b1;
            in_sample_next = s_clock_sample;
        end else if (gate_ctrl.fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg  <= egss_pkg::STEP_COUNT_RESET;
            pulse_count_reg <= egss_pkg::PULSE_COUNT_RESET;
            in_valid_reg    <= 1'b0;
        end else begin
            step_count_reg  <= step_count_next;
            pulse_count_reg <= pulse_count_next;
            in_valid_reg    <= in_valid_next;
        end
        in_sample_reg <= in_sample_next;
    end

    // Pattern builder: one step per cycle after reset or a count write
    egss_pattern #(
        .MAX_STEPS (MAX_STEPS)
    ) u_pattern (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (gate_ctrl.start),
        .eff_steps   (eff_steps),
        .pulse_count (pulse_count_reg),
        .busy        (build_busy),
        .pattern     (pattern)
    );

    // Edge detect, step counter, gate and result register
    egss_gate #(
        .MAX_STEPS (MAX_STEPS)
    ) u_gate (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (gate_ctrl),
        .eff_steps      (eff_steps),
        .pattern        (pattern),
        .sample         (in_sample_reg),
        .m_ready        (m_ready),
        .wrap_busy      (wrap_busy),
        .take           (take),
        .m_valid        (m_valid),
        .m_gated_sample (m_gated_sample)
    );

endmodule

@@ hdl/egss_checker.sv @@
// ----------------------------------------------------------------------------
// egss_checker
// Port-level checks for the gated step sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module egss_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [egss_pkg::SAMPLE_W-1:0]  m_gated_sample,
    input logic                                  cfg_valid,
    input logic                                  cfg_ready,
    input logic [egss_pkg::CFG_INDEX_W-1:0]      cfg_index
);

    // A stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_gated_sample))
        else $error("result changed while stalled");

    // Reset leaves no result and starts the pattern rebuild
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready && !cfg_ready)
        else $error("block not quiet after reset");

    // A count write starts a rebuild that blocks requests
    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready &&
        ((cfg_index == egss_pkg::CFG_STEP_COUNT) ||
         (cfg_index == egss_pkg::CFG_PULSE_COUNT))
        |=> !s_ready && !cfg_ready)
        else $error("request taken during pattern rebuild");

    // A request taken into an empty pipe with the output free yields a result
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid && !cfg_valid |=> ##1 m_valid)
        else $error("accepted request produced no result");

endmodule

bind euclidean_gated_step_sequencer egss_checker u_egss_checker (.*);
